/* rtl/core/i2cm_pkg.sv */
// shared types, codes and defaults for the i2c master transaction block
`default_nettype none
package i2cm_pkg;

  localparam int unsigned COUNT_WIDTH_DEF = 16;
  localparam int unsigned BITS_PER_BYTE   = 8;
  localparam logic [7:0]  BYTE_MSB        = 8'h80;

  // request codes as seen on the input
  localparam logic [1:0] REQ_TICK  = 2'd0;
  localparam logic [1:0] REQ_WRITE = 2'd1;
  localparam logic [1:0] REQ_READ  = 2'd2;

  // classified commands handed to the engine
  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  // status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_ADDR_NACK = 2'd1;
  localparam logic [1:0] ST_DATA_NACK = 2'd2;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [6:0]  slave_addr;
    logic [15:0] xfer_length;
    logic [7:0]  data_byte;
    logic        sda_in;
  } in_item_t;

  typedef struct packed {
    logic        scl_out;
    logic        sda_out;
    logic        busy_res;
    logic        data_taken;
    logic [7:0]  read_byte;
    logic        read_valid;
    logic        done_res;
    logic [1:0]  status;
    logic [15:0] nack_index;
  } out_item_t;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [6:0]  addr;
    logic [15:0] len;
    logic [7:0]  data;
    logic        sda;
  } cmd_item_t;

endpackage
`default_nettype wire

/* rtl/core/i2cm_fifo.sv */
// two-entry queue of packed words
`default_nettype none
module i2cm_fifo #(
  parameter int unsigned WIDTH = 8
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  output logic                  full,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      rdata,
  output logic                  empty
);

  logic [WIDTH-1:0] mem_r [2];
  logic             wptr_r;
  logic             wptr_nxt;
  logic             rptr_r;
  logic             rptr_nxt;
  logic [1:0]       cnt_r;
  logic [1:0]       cnt_nxt;
  logic             push_ok;
  logic             pop_ok;

  assign full    = (cnt_r == 2'd2);
  assign empty   = (cnt_r == 2'd0);
  assign push_ok = push && !full;
  assign pop_ok  = pop && !empty;
  assign rdata   = mem_r[rptr_r];

  always_comb begin
    wptr_nxt = push_ok ? ~wptr_r : wptr_r;
    rptr_nxt = pop_ok ? ~rptr_r : rptr_r;
    cnt_nxt  = cnt_r + {1'b0, push_ok} - {1'b0, pop_ok};
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      mem_r[wptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

/* rtl/core/i2cm_front.sv */
// input side: takes items, classifies the request and queues them for the engine
`default_nettype none
module i2cm_front
  import i2cm_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_push,
  input  wire in_item_t  in_data,
  output logic           in_full,
  input  wire logic      cmd_pop,
  output cmd_item_t      cmd_item,
  output logic           cmd_empty
);

  cmd_item_t cls;
  logic [$bits(cmd_item_t)-1:0] q_rdata;

  always_comb begin
    cls.addr = in_data.slave_addr;
    cls.len  = in_data.xfer_length;
    cls.data = in_data.data_byte;
    cls.sda  = in_data.sda_in;
    case (in_data.req_type)
      REQ_WRITE: cls.cmd = CMD_WRITE;
      REQ_READ:  cls.cmd = CMD_READ;
      default:   cls.cmd = CMD_TICK;
    endcase
  end

  i2cm_fifo #(
    .WIDTH($bits(cmd_item_t))
  ) u_cmd_q (
    .clk  (clk),
    .rst_n(rst_n),
    .push (in_push),
    .wdata(cls),
    .full (in_full),
    .pop  (cmd_pop),
    .rdata(q_rdata),
    .empty(cmd_empty)
  );

  assign cmd_item = cmd_item_t'(q_rdata);

endmodule
`default_nettype wire

/* rtl/core/i2cm_engine.sv */
// bus engine: prescaler, phase sequencer and line drive, one item per step
`default_nettype none
module i2cm_engine
  import i2cm_pkg::*;
#(
  parameter int unsigned COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [15:0] cfg_data,
  input  wire cmd_item_t   cmd_item,
  input  wire logic        cmd_empty,
  output logic             cmd_pop,
  output out_item_t        res_item,
  input  wire logic        res_full,
  output logic             res_push
);

  localparam int unsigned CW = COUNT_WIDTH;

  localparam logic [3:0] PH_IDLE     = 4'd0;
  localparam logic [3:0] PH_START    = 4'd1;
  localparam logic [3:0] PH_ABIT     = 4'd2;
  localparam logic [3:0] PH_WBIT     = 4'd3;
  localparam logic [3:0] PH_ACK_ADDR = 4'd4;
  localparam logic [3:0] PH_ACK_DATA = 4'd5;
  localparam logic [3:0] PH_RBIT     = 4'd6;
  localparam logic [3:0] PH_MACK     = 4'd7;
  localparam logic [3:0] PH_STOP     = 4'd8;

  localparam logic [2:0] LAST_BIT = 3'(BITS_PER_BYTE - 1);

  logic [15:0]   div_r;
  logic [3:0]    phase_r, phase_nxt;
  logic [2:0]    qc_r, qc_nxt;
  logic [15:0]   pre_r, pre_nxt;
  logic [2:0]    bit_r, bit_nxt;
  logic [7:0]    shift_r, shift_nxt;
  logic [CW-1:0] bc_r, bc_nxt;
  logic [CW-1:0] len_r, len_nxt;
  logic          rd_r, rd_nxt;
  logic [1:0]    lines_r, lines_nxt;   // bit 1 scl, bit 0 sda

  logic          step;
  logic [15:0]   div_eff;
  logic          q_edge;
  logic [2:0]    c;
  logic [CW-1:0] bc_inc;
  logic          more_after;
  logic          taken, rvalid, done;
  logic [7:0]    rbyte;
  logic [1:0]    stat;
  logic [15:0]   nidx;

  assign cfg_ready = 1'b1;
  assign step      = !cmd_empty && !res_full;
  assign cmd_pop   = step;
  assign res_push  = step;

  assign div_eff    = (div_r == 16'd0) ? 16'd1 : div_r;
  assign q_edge     = ({1'b0, pre_r} + 17'd1) >= {1'b0, div_eff};
  assign c          = qc_r + 3'd1;
  assign bc_inc     = bc_r + CW'(1);
  assign more_after = ({1'b0, bc_r} + (CW+1)'(1)) < {1'b0, len_r};

  always_comb begin
    phase_nxt = phase_r;
    qc_nxt    = qc_r;
    pre_nxt   = pre_r;
    bit_nxt   = bit_r;
    shift_nxt = shift_r;
    bc_nxt    = bc_r;
    len_nxt   = len_r;
    rd_nxt    = rd_r;
    lines_nxt = lines_r;
    taken     = 1'b0;
    rvalid    = 1'b0;
    rbyte     = 8'd0;
    done      = 1'b0;
    stat      = ST_OK;
    nidx      = 16'd0;

    if (phase_r == PH_IDLE) begin
      if (cmd_item.cmd == CMD_WRITE || cmd_item.cmd == CMD_READ) begin
        rd_nxt    = (cmd_item.cmd == CMD_READ);
        len_nxt   = cmd_item.len[CW-1:0];
        bc_nxt    = '0;
        bit_nxt   = 3'd0;
        shift_nxt = {cmd_item.addr, (cmd_item.cmd == CMD_READ)};
        pre_nxt   = 16'd0;
        phase_nxt = PH_START;
        qc_nxt    = 3'd0;
        lines_nxt = 2'b10;
      end
    end else if (!q_edge) begin
      pre_nxt = pre_r + 16'd1;
    end else begin
      pre_nxt = 16'd0;
      qc_nxt  = c;
      case (phase_r)
        PH_START: begin
          if (c == 3'd2) begin
            lines_nxt[1] = 1'b0;
          end else if (c >= 3'd3) begin
            bit_nxt   = 3'd0;
            phase_nxt = PH_ABIT;
            qc_nxt    = 3'd0;
          end
        end
        PH_ABIT, PH_WBIT: begin
          if (c == 3'd1) begin
            lines_nxt = {1'b1, (shift_r & BYTE_MSB) != 8'd0};
          end else if (c == 3'd2) begin
            lines_nxt[1] = 1'b0;
          end else if (c >= 3'd3) begin
            shift_nxt = {shift_r[6:0], 1'b0};
            qc_nxt    = 3'd0;
            if (bit_r >= LAST_BIT) begin
              bit_nxt   = 3'd0;
              phase_nxt = (phase_r == PH_ABIT) ? PH_ACK_ADDR : PH_ACK_DATA;
              lines_nxt = 2'b11;
            end else begin
              bit_nxt = bit_r + 3'd1;
            end
          end
        end
        PH_ACK_ADDR, PH_ACK_DATA: begin
          if (c == 3'd2) begin
            shift_nxt    = {7'd0, cmd_item.sda};
            lines_nxt[1] = 1'b0;
          end else if (c >= 3'd3) begin
            qc_nxt = 3'd0;
            if (shift_r[0]) begin
              phase_nxt    = PH_STOP;
              shift_nxt    = {6'd0, (phase_r == PH_ACK_ADDR) ? ST_ADDR_NACK : ST_DATA_NACK};
              lines_nxt[0] = 1'b0;
            end else begin
              // a data ack counts the byte just sent before the length check
              if (phase_r == PH_ACK_DATA) begin
                bc_nxt = bc_inc;
              end
              if (((phase_r == PH_ACK_DATA) ? bc_inc : bc_r) >= len_r) begin
                phase_nxt    = PH_STOP;
                shift_nxt    = {6'd0, ST_OK};
                lines_nxt[0] = 1'b0;
              end else if (rd_r) begin
                bit_nxt      = 3'd0;
                phase_nxt    = PH_RBIT;
                lines_nxt[0] = 1'b1;
              end else begin
                shift_nxt = cmd_item.data;
                taken     = 1'b1;
                bit_nxt   = 3'd0;
                phase_nxt = PH_WBIT;
              end
            end
          end
        end
        PH_RBIT: begin
          if (c == 3'd2) begin
            lines_nxt[1] = 1'b1;
          end else if (c == 3'd4) begin
            shift_nxt    = {shift_r[6:0], cmd_item.sda};
            lines_nxt[1] = 1'b0;
            if (bit_r >= LAST_BIT) begin
              rvalid = 1'b1;
              rbyte  = {shift_r[6:0], cmd_item.sda};
            end
          end else if (c >= 3'd6) begin
            qc_nxt = 3'd0;
            if (bit_r >= LAST_BIT) begin
              bit_nxt   = 3'd0;
              phase_nxt = PH_MACK;
              // ack every byte but the last, which gets a nack
              lines_nxt = {1'b1, !more_after};
            end else begin
              bit_nxt      = bit_r + 3'd1;
              phase_nxt    = PH_RBIT;
              lines_nxt[0] = 1'b1;
            end
          end
        end
        PH_MACK: begin
          if (c == 3'd1) begin
            lines_nxt[1] = 1'b0;
          end else if (c >= 3'd2) begin
            bc_nxt = bc_inc;
            qc_nxt = 3'd0;
            if (bc_inc >= len_r) begin
              phase_nxt    = PH_STOP;
              shift_nxt    = {6'd0, ST_OK};
              lines_nxt[0] = 1'b0;
            end else begin
              phase_nxt    = PH_RBIT;
              lines_nxt[0] = 1'b1;
            end
          end
        end
        PH_STOP: begin
          if (c == 3'd1) begin
            lines_nxt[1] = 1'b1;
          end else if (c == 3'd3) begin
            lines_nxt[0] = 1'b1;
          end else if (c >= 3'd4) begin
            done      = 1'b1;
            stat      = shift_r[1:0];
            nidx      = (shift_r[1:0] == ST_DATA_NACK) ? 16'(bc_r) : 16'd0;
            phase_nxt = PH_IDLE;
            qc_nxt    = 3'd0;
            lines_nxt = 2'b11;
          end
        end
        default: begin
          phase_nxt = PH_IDLE;
          qc_nxt    = 3'd0;
          lines_nxt = 2'b11;
        end
      endcase
    end
  end

  always_comb begin
    res_item.scl_out    = lines_nxt[1];
    res_item.sda_out    = lines_nxt[0];
    res_item.busy_res   = (phase_nxt != PH_IDLE);
    res_item.data_taken = taken;
    res_item.read_byte  = rbyte;
    res_item.read_valid = rvalid;
    res_item.done_res   = done;
    res_item.status     = stat;
    res_item.nack_index = nidx;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_r   <= 16'd1;
      phase_r <= PH_IDLE;
      qc_r    <= 3'd0;
      pre_r   <= 16'd0;
      bit_r   <= 3'd0;
      shift_r <= 8'd0;
      bc_r    <= '0;
      len_r   <= '0;
      rd_r    <= 1'b0;
      lines_r <= 2'b11;
    end else begin
      if (cfg_valid) begin
        div_r <= cfg_data;
      end
      if (step) begin
        phase_r <= phase_nxt;
        qc_r    <= qc_nxt;
        pre_r   <= pre_nxt;
        bit_r   <= bit_nxt;
        shift_r <= shift_nxt;
        bc_r    <= bc_nxt;
        len_r   <= len_nxt;
        rd_r    <= rd_nxt;
        lines_r <= lines_nxt;
      end
    end
  end

endmodule
`default_nettype wire

/* rtl/core/i2c_master_transaction_top.sv */
// top level of the tick-driven i2c master transaction block
`default_nettype none
// Each input item is one tick of time carrying a request, the sampled SDA level
// and the next write byte; each item yields exactly one result item with the
// SCL/SDA drive levels and transfer status after that tick. Items are taken one
// per clock and results leave one per clock when both sides keep moving. The
// engine takes an item from the input queue and, in the same cycle, evaluates
// the whole tick combinationally and writes its result into the result queue,
// from which it can be popped; it holds only while the input queue is empty or
// the result queue is full. Requests that arrive while a transfer is running
// are ignored. The quantum divider is to be written through the cfg port only
// while no items are in flight; the block itself does not enforce this. A
// lowered divider ends a running quantum at once.
module i2c_master_transaction_top
  import i2cm_pkg::*;
#(
  parameter int unsigned COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_push,
  input  wire in_item_t    in_data,
  output logic             in_full,
  output logic             out_empty,
  input  wire logic        out_pop,
  output out_item_t        out_data,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [15:0] cfg_data
);

  cmd_item_t cmd_item;
  logic      cmd_empty;
  logic      cmd_pop;
  out_item_t res_item;
  logic      res_full;
  logic      res_push;
  logic [$bits(out_item_t)-1:0] out_rdata;

  i2cm_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_data  (in_data),
    .in_full  (in_full),
    .cmd_pop  (cmd_pop),
    .cmd_item (cmd_item),
    .cmd_empty(cmd_empty)
  );

  i2cm_engine #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_engine (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data),
    .cmd_item (cmd_item),
    .cmd_empty(cmd_empty),
    .cmd_pop  (cmd_pop),
    .res_item (res_item),
    .res_full (res_full),
    .res_push (res_push)
  );

  i2cm_fifo #(
    .WIDTH($bits(out_item_t))
  ) u_res_q (
    .clk  (clk),
    .rst_n(rst_n),
    .push (res_push),
    .wdata(res_item),
    .full (res_full),
    .pop  (out_pop),
    .rdata(out_rdata),
    .empty(out_empty)
  );

  assign out_data = out_item_t'(out_rdata);

endmodule
`default_nettype wire
